// ===== rtl/tpt_pkg.sv =====
// Shared types for the TLB page translation unit.
// No dependencies; imported by tpt_tlb and the top level.
`timescale 1ns / 1ps

package tpt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } tpt_state_t;

    // Update commands from the sequencer to the TLB
    typedef struct packed {
        logic inv_en;   // drop every entry that holds inv_page
        logic ins_en;   // write a translation at the FIFO slot
    } tlb_ctrl_t;

endpackage

// ===== rtl/tpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tpt_tlb.sv =====
// Fully associative TLB with FIFO slot replacement and invalidate-by-page.
// Depends on tpt_pkg (tlb_ctrl_t).
`timescale 1ns / 1ps

module tpt_tlb import tpt_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlb_ctrl_t          ctrl,
    input  logic [PAGE_W-1:0]  lookup_page,
    input  logic [PAGE_W-1:0]  inv_page,
    input  logic [PAGE_W-1:0]  ins_page,
    input  logic [FRAME_W-1:0] ins_frame,
    output logic               hit,
    output logic [FRAME_W-1:0] frame
);

    localparam int SLOT_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] valid_reg;
    logic [PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [FRAME_W-1:0] frame_reg [ENTRIES];
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;

    // Lowest matching entry wins
    always_comb
    begin
        hit   = 1'b0;
        frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (page_reg[i] == lookup_page))
            begin
                hit   = 1'b1;
                frame = frame_reg[i];
            end
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.ins_en)
        begin
            if (slot_reg == SLOT_W'(ENTRIES - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (ctrl.inv_en && valid_reg[i] && (page_reg[i] == inv_page))
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            // Insert after the invalidate so the new entry survives
            if (ctrl.ins_en)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            page_reg[slot_reg]  <= ins_page;
            frame_reg[slot_reg] <= ins_frame;
        end
    end

endmodule

// ===== rtl/tlb_page_translation_fifo_unit.sv =====
// TLB page translation unit: start is taken only while idle, and busy holds off a new
// item until the current one leaves its execute state (both memories are read at the
// accepting edge; busy then covers the read-modify-write cycle that follows). The result
// shows on the cycle after that write, for one cycle, with no stall from the receiver.
// Reset clears the TLB, the page valid bits, the frame pointer and both counters.
// Depends on tpt_pkg, tpt_ram and tpt_tlb; NUM_PAGES and NUM_FRAMES are powers of two.
`timescale 1ns / 1ps

module tlb_page_translation_fifo_unit import tpt_pkg::*; #(
    parameter int TLB_ENTRIES = 16,
    parameter int NUM_PAGES   = 256,
    parameter int NUM_FRAMES  = 128,
    parameter int OFFSET_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] logical_address,
    output logic        busy,
    output logic        done,
    output logic [14:0] physical_address,
    output logic        tlb_hit,
    output logic        page_fault,
    output logic        evict_valid,
    output logic [7:0]  evicted_page,
    output logic [31:0] hit_total,
    output logic [31:0] fault_total
);

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int FRAME_W = $clog2(NUM_FRAMES);

    tpt_state_t state_reg, state_next;

    logic                 accept;
    logic                 exec;
    logic [15:0]          in_shift;
    logic [PAGE_W-1:0]    in_page;
    logic [15:0]          addr_reg;
    logic [15:0]          addr_shift;
    logic [PAGE_W-1:0]    page;
    logic [OFFSET_BITS-1:0] offset;

    logic [NUM_PAGES-1:0] pvalid_reg;
    logic [FRAME_W-1:0]   frame_next_reg, frame_next_next;
    logic                 full_reg, full_next;
    logic [31:0]          hit_cnt_reg, hit_cnt_next;
    logic [31:0]          fault_cnt_reg, fault_cnt_next;

    logic [FRAME_W-1:0]   pm_rdata;
    logic [PAGE_W-1:0]    owner_rdata;

    logic                 fault;
    logic                 evict;
    logic                 hit;
    logic                 tlb_match;
    logic [FRAME_W-1:0]   tlb_frame;
    logic [FRAME_W-1:0]   frame_sel;
    tlb_ctrl_t            tlb_ctrl;
    logic [31:0]          pa_wide;
    logic [31:0]          old_wide;

    logic                 done_reg;
    logic [14:0]          pa_reg;
    logic                 hit_out_reg;
    logic                 fault_out_reg;
    logic                 evict_out_reg;
    logic [7:0]           evpage_reg;

    assign exec   = (state_reg == ST_EXEC);
    assign busy   = exec;
    assign accept = start && !busy;

    assign in_shift   = logical_address >> OFFSET_BITS;
    assign in_page    = in_shift[PAGE_W-1:0];
    assign addr_shift = addr_reg >> OFFSET_BITS;
    assign page       = addr_shift[PAGE_W-1:0];
    assign offset     = addr_reg[OFFSET_BITS-1:0];

    // Page table: frame per page, validity kept in pvalid_reg
    tpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_PAGES)
    ) u_page_map (
        .clk   (clk),
        .we    (exec && fault),
        .waddr (page),
        .wdata (frame_next_reg),
        .re    (accept),
        .raddr (in_page),
        .rdata (pm_rdata)
    );

    // Owner page per frame, read at the FIFO pointer
    tpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_FRAMES)
    ) u_frame_owner (
        .clk   (clk),
        .we    (exec && fault),
        .waddr (frame_next_reg),
        .wdata (page),
        .re    (accept),
        .raddr (frame_next_reg),
        .rdata (owner_rdata)
    );

    assign fault = !pvalid_reg[page];
    assign evict = fault && full_reg;
    assign hit   = !fault && tlb_match;

    always_comb
    begin
        tlb_ctrl.inv_en = exec && evict;
        tlb_ctrl.ins_en = exec && !hit;
    end

    tpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W),
        .FRAME_W (FRAME_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (tlb_ctrl),
        .lookup_page (page),
        .inv_page    (owner_rdata),
        .ins_page    (page),
        .ins_frame   (frame_sel),
        .hit         (tlb_match),
        .frame       (tlb_frame)
    );

    always_comb
    begin
        priority if (fault)
        begin
            frame_sel = frame_next_reg;
        end
        else if (tlb_match)
        begin
            frame_sel = tlb_frame;
        end
        else
        begin
            frame_sel = pm_rdata;
        end
    end

    assign pa_wide  = (32'(frame_sel) << OFFSET_BITS) + 32'(offset);
    assign old_wide = 32'(owner_rdata);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        frame_next_next = frame_next_reg;
        full_next       = full_reg;
        hit_cnt_next    = hit_cnt_reg;
        fault_cnt_next  = fault_cnt_reg;
        if (exec && fault)
        begin
            if (frame_next_reg == FRAME_W'(NUM_FRAMES - 1))
            begin
                frame_next_next = '0;
                full_next       = 1'b1;
            end
            else
            begin
                frame_next_next = frame_next_reg + 1'b1;
            end
            if (fault_cnt_reg != 32'hFFFF_FFFF)
            begin
                fault_cnt_next = fault_cnt_reg + 32'd1;
            end
        end
        if (exec && hit && (hit_cnt_reg != 32'hFFFF_FFFF))
        begin
            hit_cnt_next = hit_cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pvalid_reg     <= '0;
            frame_next_reg <= '0;
            full_reg       <= 1'b0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_next_reg <= frame_next_next;
            full_reg       <= full_next;
            hit_cnt_reg    <= hit_cnt_next;
            fault_cnt_reg  <= fault_cnt_next;
            done_reg       <= exec;
            if (exec && evict)
            begin
                pvalid_reg[owner_rdata] <= 1'b0;
            end
            // Evicted page never equals the faulting page, so the order is safe
            if (exec && fault)
            begin
                pvalid_reg[page] <= 1'b1;
            end
        end
    end

    // Hold the address during the lookup cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= logical_address;
        end
        if (exec)
        begin
            pa_reg        <= pa_wide[14:0];
            hit_out_reg   <= hit;
            fault_out_reg <= fault;
            evict_out_reg <= evict;
            evpage_reg    <= evict ? old_wide[7:0] : 8'd0;
        end
    end

    assign done             = done_reg;
    assign physical_address = pa_reg;
    assign tlb_hit          = hit_out_reg;
    assign page_fault       = fault_out_reg;
    assign evict_valid      = evict_out_reg;
    assign evicted_page     = evpage_reg;
    assign hit_total        = hit_cnt_reg;
    assign fault_total      = fault_cnt_reg;

endmodule
